>>> rtl/adu_pkg.sv
// Shared types, constants and the division step for the fixed-point Adam update engine.
// No dependencies; every other file in rtl/ imports this package.
package adu_pkg;

   // Moment store depth. It must be a power of two no larger than 4096, so that the
   // store position is simply the low bits of the 12-bit element index.
   localparam int ELEMENTS = 4096;
   localparam int POS_W = $clog2(ELEMENTS);

   localparam logic [31:0] ONE_Q131 = 32'h8000_0000;
   localparam logic [16:0] ONE_Q016 = 17'h1_0000;

   localparam int BCDIV_STAGES = 32;
   localparam int SQRT_STAGES = 24;
   localparam int STEP_STAGES = 48;

   // Request actions.
   localparam logic ACT_BEGIN_STEP = 1'b0;
   localparam logic ACT_ELEMENT = 1'b1;

   // What every element carries down the pipeline; also the shape of a result.
   typedef struct packed {
      logic [11:0] idx;
      logic signed [31:0] param;
      logic sat;
   } tag_type;

   typedef struct packed {
      logic [23:0] lr;
      logic [15:0] beta1;
      logic [15:0] beta2;
      logic [15:0] eps;
   } cfg_type;

   typedef struct packed {
      tag_type tag;
      logic signed [31:0] m;
      logic [31:0] v;
      logic [31:0] bc1;
      logic [31:0] bc2;
   } mom_type;

   typedef struct packed {
      tag_type tag;
      logic neg;
      logic [31:0] mh;
      logic [31:0] vh;
   } bias_type;

   typedef struct packed {
      tag_type tag;
      logic neg;
      logic [31:0] mh;
      logic [23:0] root;
   } root_type;

   typedef struct packed {
      tag_type tag;
      logic neg;
      logic [47:0] num;
      logic [24:0] den;
   } quot_type;

   typedef struct packed {
      tag_type tag;
      logic neg;
      logic [47:0] step;
   } step_type;

   // One restoring division step: shift one dividend bit into the remainder and
   // subtract the divisor if it fits. Returns {quotient bit, new remainder}.
   // The caller keeps the remainder below the divisor, which is below 2^32.
   function automatic logic [32:0] div_step(input logic [31:0] rem, input logic shin,
                                            input logic [31:0] dvs);
      logic [32:0] sh;
      logic [32:0] diff;
      sh = {rem, shin};
      diff = sh - {1'b0, dvs};
      if (sh >= {1'b0, dvs}) begin
         div_step = {1'b1, diff[31:0]};
      end else begin
         div_step = {1'b0, sh[31:0]};
      end
   endfunction

endpackage

>>> rtl/adu_moments.sv
// Moment stores and their read-modify-write pipeline, plus the two kept beta powers.
// Depends on adu_pkg.
module adu_moments
   import adu_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic adv,
   input  logic in_valid,
   input  logic in_action,
   input  logic [11:0] in_index,
   input  logic signed [31:0] in_param,
   input  logic signed [31:0] in_grad,
   input  cfg_type cfg,
   output logic busy,
   output logic out_valid,
   output mom_type out
);

   // Request stage
   logic p0_valid_ff;
   logic p0_act_ff;
   logic [11:0] p0_idx_ff;
   logic signed [31:0] p0_param_ff;
   logic signed [31:0] p0_grad_ff;

   // Update stage
   logic s1_valid_ff;
   logic [11:0] s1_idx_ff;
   logic signed [31:0] s1_param_ff;
   logic signed [31:0] s1_grad_ff;
   logic [63:0] s1_gsq_ff;
   logic [31:0] s1_bc1_ff;
   logic [31:0] s1_bc2_ff;
   logic [31:0] rd_m_ff;
   logic [31:0] rd_v_ff;

   logic [31:0] pow1_ff;
   logic [31:0] pow2_ff;
   logic [POS_W:0] clr_ff;

   logic wb_valid_ff;
   logic [POS_W-1:0] wb_pos_ff;
   logic [31:0] wb_m_ff;
   logic [31:0] wb_v_ff;

   logic out_valid_ff;
   mom_type out_ff;

   logic [31:0] first_mem [ELEMENTS];
   logic [31:0] second_mem [ELEMENTS];

   logic [POS_W-1:0] p0_pos;
   logic [POS_W-1:0] s1_pos;
   logic [31:0] gmag;
   logic [31:0] bc1;
   logic [31:0] bc2;
   logic [31:0] m_old;
   logic [31:0] v_old;
   logic [31:0] g2;
   logic g2_sat;
   logic [16:0] c1;
   logic [16:0] c2;
   logic signed [32:0] dm;
   logic signed [32:0] dv;
   logic signed [50:0] pm;
   logic signed [50:0] pv;
   logic [31:0] m_new;
   logic [31:0] v_new;
   logic wr_en;

   assign busy = (clr_ff != (POS_W+1)'(ELEMENTS));
   assign p0_pos = p0_idx_ff[POS_W-1:0];
   assign s1_pos = s1_idx_ff[POS_W-1:0];
   assign wr_en = adv && s1_valid_ff;

   always_comb begin
      gmag = p0_grad_ff[31] ? 32'(-p0_grad_ff) : 32'(p0_grad_ff);
      // A power still at 1.0 gives no correction, which is the same as dividing by 1.0.
      bc1 = ONE_Q131 - pow1_ff;
      bc2 = ONE_Q131 - pow2_ff;
      if (bc1 == 32'd0) begin
         bc1 = ONE_Q131;
      end
      if (bc2 == 32'd0) begin
         bc2 = ONE_Q131;
      end
   end

   // The last write lands at the same edge as the next read, which returns the old
   // word, so the update stage takes the write-back copy when positions match.
   always_comb begin
      m_old = (wb_valid_ff && wb_pos_ff == s1_pos) ? wb_m_ff : rd_m_ff;
      v_old = (wb_valid_ff && wb_pos_ff == s1_pos) ? wb_v_ff : rd_v_ff;
      g2_sat = (s1_gsq_ff[63:48] != 16'd0);
      g2 = g2_sat ? 32'hFFFF_FFFF : s1_gsq_ff[47:16];
      c1 = ONE_Q016 - {1'b0, cfg.beta1};
      c2 = ONE_Q016 - {1'b0, cfg.beta2};
      // new = old + floor((1 - beta) * (x - old)), the same as the convex mix.
      dm = $signed({s1_grad_ff[31], s1_grad_ff}) - $signed({m_old[31], m_old});
      dv = $signed({1'b0, g2}) - $signed({1'b0, v_old});
      pm = $signed({1'b0, c1}) * dm;
      pv = $signed({1'b0, c2}) * dv;
      m_new = m_old + 32'(pm >>> 16);
      v_new = v_old + 32'(pv >>> 16);
   end

   always_ff @(posedge clock) begin
      if (busy) begin
         first_mem[clr_ff[POS_W-1:0]] <= 32'd0;
      end else if (wr_en) begin
         first_mem[s1_pos] <= m_new;
      end
      if (adv) begin
         rd_m_ff <= first_mem[p0_pos];
      end
   end

   always_ff @(posedge clock) begin
      if (busy) begin
         second_mem[clr_ff[POS_W-1:0]] <= 32'd0;
      end else if (wr_en) begin
         second_mem[s1_pos] <= v_new;
      end
      if (adv) begin
         rd_v_ff <= second_mem[p0_pos];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         wb_valid_ff <= 1'b0;
         pow1_ff <= ONE_Q131;
         pow2_ff <= ONE_Q131;
         clr_ff <= '0;
      end else begin
         if (busy) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (adv) begin
            p0_valid_ff <= in_valid;
            s1_valid_ff <= p0_valid_ff && (p0_act_ff == ACT_ELEMENT);
            out_valid_ff <= s1_valid_ff;
            if (p0_valid_ff && (p0_act_ff == ACT_BEGIN_STEP)) begin
               pow1_ff <= 32'(({32'd0, pow1_ff} * {48'd0, cfg.beta1}) >> 16);
               pow2_ff <= 32'(({32'd0, pow2_ff} * {48'd0, cfg.beta2}) >> 16);
            end
            if (wr_en) begin
               wb_valid_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p0_act_ff <= in_action;
         p0_idx_ff <= in_index;
         p0_param_ff <= in_param;
         p0_grad_ff <= in_grad;
         s1_idx_ff <= p0_idx_ff;
         s1_param_ff <= p0_param_ff;
         s1_grad_ff <= p0_grad_ff;
         s1_gsq_ff <= {32'd0, gmag} * {32'd0, gmag};
         s1_bc1_ff <= bc1;
         s1_bc2_ff <= bc2;
         out_ff.tag.idx <= s1_idx_ff;
         out_ff.tag.param <= s1_param_ff;
         out_ff.tag.sat <= g2_sat;
         out_ff.m <= m_new;
         out_ff.v <= v_new;
         out_ff.bc1 <= s1_bc1_ff;
         out_ff.bc2 <= s1_bc2_ff;
         if (wr_en) begin
            wb_pos_ff <= s1_pos;
            wb_m_ff <= m_new;
            wb_v_ff <= v_new;
         end
      end
   end

   assign out_valid = out_valid_ff;
   assign out = out_ff;

endmodule

>>> rtl/adu_bcdiv.sv
// Bias correction: two pipelined restoring dividers, m*2^31/bc1 and v*2^31/bc2.
// Depends on adu_pkg.
module adu_bcdiv
   import adu_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic adv,
   input  logic in_valid,
   input  mom_type in,
   output logic out_valid,
   output bias_type out
);

   logic [BCDIV_STAGES:0] vld_ff;
   tag_type tag_ff [BCDIV_STAGES+1];
   logic neg_ff [BCDIV_STAGES+1];
   logic ovfm_ff [BCDIV_STAGES+1];
   logic ovfv_ff [BCDIV_STAGES+1];
   logic [31:0] mrem_ff [BCDIV_STAGES+1];
   logic [31:0] vrem_ff [BCDIV_STAGES+1];
   logic [31:0] mq_ff [BCDIV_STAGES+1];
   logic [31:0] vq_ff [BCDIV_STAGES+1];
   logic [31:0] mdvs_ff [BCDIV_STAGES+1];
   logic [31:0] vdvs_ff [BCDIV_STAGES+1];
   logic mlow_ff;
   logic vlow_ff;

   logic out_valid_ff;
   bias_type out_ff;

   logic [31:0] mmag;
   logic [31:0] mlim;
   logic [31:0] mq;
   logic [31:0] vq;

   assign mmag = in.m[31] ? 32'(-in.m) : 32'(in.m);

   // Entry stage: the quotient fits 32 bits only while the dividend is below twice the divisor.
   always_ff @(posedge clock) begin
      if (adv) begin
         tag_ff[0] <= in.tag;
         neg_ff[0] <= in.m[31];
         ovfm_ff[0] <= ({1'b0, mmag} >= {in.bc1, 1'b0});
         ovfv_ff[0] <= ({1'b0, in.v} >= {in.bc2, 1'b0});
         mrem_ff[0] <= {1'b0, mmag[31:1]};
         vrem_ff[0] <= {1'b0, in.v[31:1]};
         mlow_ff <= mmag[0];
         vlow_ff <= in.v[0];
         mq_ff[0] <= 32'd0;
         vq_ff[0] <= 32'd0;
         mdvs_ff[0] <= in.bc1;
         vdvs_ff[0] <= in.bc2;
      end
   end

   for (genvar k = 0; k < BCDIV_STAGES; k++) begin : g_stage
      logic [32:0] mres;
      logic [32:0] vres;
      assign mres = div_step(mrem_ff[k], (k == 0) ? mlow_ff : 1'b0, mdvs_ff[k]);
      assign vres = div_step(vrem_ff[k], (k == 0) ? vlow_ff : 1'b0, vdvs_ff[k]);
      always_ff @(posedge clock) begin
         if (adv) begin
            tag_ff[k+1] <= tag_ff[k];
            neg_ff[k+1] <= neg_ff[k];
            ovfm_ff[k+1] <= ovfm_ff[k];
            ovfv_ff[k+1] <= ovfv_ff[k];
            mrem_ff[k+1] <= mres[31:0];
            vrem_ff[k+1] <= vres[31:0];
            mq_ff[k+1] <= {mq_ff[k][30:0], mres[32]};
            vq_ff[k+1] <= {vq_ff[k][30:0], vres[32]};
            mdvs_ff[k+1] <= mdvs_ff[k];
            vdvs_ff[k+1] <= vdvs_ff[k];
         end
      end
   end

   always_comb begin
      mlim = neg_ff[BCDIV_STAGES] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      mq = mq_ff[BCDIV_STAGES];
      vq = vq_ff[BCDIV_STAGES];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= {vld_ff[BCDIV_STAGES-1:0], in_valid};
         out_valid_ff <= vld_ff[BCDIV_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff.tag.idx <= tag_ff[BCDIV_STAGES].idx;
         out_ff.tag.param <= tag_ff[BCDIV_STAGES].param;
         out_ff.tag.sat <= tag_ff[BCDIV_STAGES].sat || ovfm_ff[BCDIV_STAGES]
                           || (mq > mlim) || ovfv_ff[BCDIV_STAGES];
         out_ff.neg <= neg_ff[BCDIV_STAGES];
         out_ff.mh <= (ovfm_ff[BCDIV_STAGES] || (mq > mlim)) ? mlim : mq;
         out_ff.vh <= ovfv_ff[BCDIV_STAGES] ? 32'hFFFF_FFFF : vq;
      end
   end

   assign out_valid = out_valid_ff;
   assign out = out_ff;

endmodule

>>> rtl/adu_sqrt.sv
// Pipelined digit-by-digit square root of v_hat in Q16.16, one root bit per stage.
// Depends on adu_pkg.
module adu_sqrt
   import adu_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic adv,
   input  logic in_valid,
   input  bias_type in,
   output logic out_valid,
   output root_type out
);

   logic [SQRT_STAGES:0] vld_ff;
   tag_type tag_ff [SQRT_STAGES+1];
   logic neg_ff [SQRT_STAGES+1];
   logic [31:0] mh_ff [SQRT_STAGES+1];
   logic [31:0] rad_ff [SQRT_STAGES+1];
   logic [25:0] rem_ff [SQRT_STAGES+1];
   logic [23:0] root_ff [SQRT_STAGES+1];

   always_ff @(posedge clock) begin
      if (adv) begin
         tag_ff[0] <= in.tag;
         neg_ff[0] <= in.neg;
         mh_ff[0] <= in.mh;
         rad_ff[0] <= in.vh;
         rem_ff[0] <= 26'd0;
         root_ff[0] <= 24'd0;
      end
   end

   for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
      logic [47:0] x;
      logic [27:0] sh;
      logic [27:0] trial;
      logic [27:0] diff;
      assign x = {rad_ff[k], 16'h0000};
      assign sh = {rem_ff[k], x[47-2*k -: 2]};
      assign trial = {2'b00, root_ff[k], 2'b01};
      assign diff = sh - trial;
      always_ff @(posedge clock) begin
         if (adv) begin
            tag_ff[k+1] <= tag_ff[k];
            neg_ff[k+1] <= neg_ff[k];
            mh_ff[k+1] <= mh_ff[k];
            rad_ff[k+1] <= rad_ff[k];
            if (sh >= trial) begin
               rem_ff[k+1] <= diff[25:0];
               root_ff[k+1] <= {root_ff[k][22:0], 1'b1};
            end else begin
               rem_ff[k+1] <= sh[25:0];
               root_ff[k+1] <= {root_ff[k][22:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[SQRT_STAGES-1:0], in_valid};
      end
   end

   assign out_valid = vld_ff[SQRT_STAGES];
   assign out.tag = tag_ff[SQRT_STAGES];
   assign out.neg = neg_ff[SQRT_STAGES];
   assign out.mh = mh_ff[SQRT_STAGES];
   assign out.root = root_ff[SQRT_STAGES];

endmodule

>>> rtl/adu_stepdiv.sv
// Pipelined restoring divider for the step size, 48-bit quotient of (lr*m_hat/2^8)/den.
// Depends on adu_pkg.
module adu_stepdiv
   import adu_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic adv,
   input  logic in_valid,
   input  quot_type in,
   output logic out_valid,
   output step_type out
);

   logic [STEP_STAGES:0] vld_ff;
   tag_type tag_ff [STEP_STAGES+1];
   logic neg_ff [STEP_STAGES+1];
   logic [47:0] num_ff [STEP_STAGES+1];
   logic [31:0] dvs_ff [STEP_STAGES+1];
   logic [31:0] rem_ff [STEP_STAGES+1];
   logic [47:0] q_ff [STEP_STAGES+1];

   always_ff @(posedge clock) begin
      if (adv) begin
         tag_ff[0] <= in.tag;
         neg_ff[0] <= in.neg;
         num_ff[0] <= in.num;
         dvs_ff[0] <= {7'd0, in.den};
         rem_ff[0] <= 32'd0;
         q_ff[0] <= 48'd0;
      end
   end

   for (genvar k = 0; k < STEP_STAGES; k++) begin : g_stage
      logic [32:0] res;
      assign res = div_step(rem_ff[k], num_ff[k][STEP_STAGES-1-k], dvs_ff[k]);
      always_ff @(posedge clock) begin
         if (adv) begin
            tag_ff[k+1] <= tag_ff[k];
            neg_ff[k+1] <= neg_ff[k];
            num_ff[k+1] <= num_ff[k];
            dvs_ff[k+1] <= dvs_ff[k];
            rem_ff[k+1] <= res[31:0];
            q_ff[k+1] <= {q_ff[k][46:0], res[32]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[STEP_STAGES-1:0], in_valid};
      end
   end

   assign out_valid = vld_ff[STEP_STAGES];
   assign out.tag = tag_ff[STEP_STAGES];
   assign out.neg = neg_ff[STEP_STAGES];
   assign out.step = q_ff[STEP_STAGES];

endmodule

>>> rtl/adam_update.sv
// Top level of the fixed-point Adam update engine: registers, pipeline and result buffer.
// Depends on adu_pkg, adu_moments, adu_bcdiv, adu_sqrt and adu_stepdiv.
//
//   channel   direction   handshake               carries
//   req_*     in          req_valid / req_stall   action, index, param_value, gradient
//   rsp_*     out         rsp_valid / rsp_stall   out_index, new_param, saturated
//   csr_*     in/out      APB, pready always 1    step size, betas, epsilon_floor
//
// The engine takes one request per cycle while req_stall is low. The pipeline depth is
// set by the three bit-per-stage units (bias division 32 stages, square root 24 stages,
// step division 48 stages). After reset both moment stores are swept to zero, one entry
// per cycle, and req_stall stays high during that sweep.
// The whole pipeline moves together; it halts only when the two-entry result buffer is
// full, so requests keep flowing while one result waits to be taken.
module adam_update
   import adu_pkg::*;
(
   input  logic clock,
   input  logic reset,

   input  logic req_valid,
   output logic req_stall,
   input  logic req_action,
   input  logic [11:0] req_index,
   input  logic signed [31:0] req_param_value,
   input  logic signed [31:0] req_gradient,

   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [11:0] rsp_out_index,
   output logic signed [31:0] rsp_new_param,
   output logic rsp_saturated,

   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [3:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);

   localparam logic [1:0] REG_STEP_SIZE = 2'd0;
   localparam logic [1:0] REG_BETA_FIRST = 2'd1;
   localparam logic [1:0] REG_BETA_SECOND = 2'd2;
   localparam logic [1:0] REG_EPSILON_FLOOR = 2'd3;

   cfg_type cfg_ff;

   logic adv;
   logic busy;
   logic accept;
   logic csr_write;

   logic mom_valid;
   mom_type mom;
   logic bias_valid;
   bias_type bias;
   logic root_valid;
   root_type root;
   logic quot_valid_ff;
   quot_type quot_ff;
   logic step_valid;
   step_type step;
   logic fin_valid_ff;
   tag_type fin_ff;

   logic [1:0] cnt_ff;
   tag_type ent0_ff;
   tag_type ent1_ff;

   logic [24:0] den;
   logic [55:0] prod;
   logic signed [49:0] pe;
   logic signed [49:0] res;
   logic push;
   logic pop;

   // Configuration registers. Writes must arrive only while the engine is idle; the block itself does not enforce this.
   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lr <= 24'd16777;
         cfg_ff.beta1 <= 16'd58982;
         cfg_ff.beta2 <= 16'd65470;
         cfg_ff.eps <= 16'd1;
      end else if (csr_write) begin
         unique case (csr_paddr[3:2])
            REG_STEP_SIZE: cfg_ff.lr <= csr_pwdata[23:0];
            REG_BETA_FIRST: cfg_ff.beta1 <= csr_pwdata[15:0];
            REG_BETA_SECOND: cfg_ff.beta2 <= csr_pwdata[15:0];
            REG_EPSILON_FLOOR: cfg_ff.eps <= csr_pwdata[15:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_STEP_SIZE: csr_prdata = {8'd0, cfg_ff.lr};
         REG_BETA_FIRST: csr_prdata = {16'd0, cfg_ff.beta1};
         REG_BETA_SECOND: csr_prdata = {16'd0, cfg_ff.beta2};
         REG_EPSILON_FLOOR: csr_prdata = {16'd0, cfg_ff.eps};
      endcase
   end

   // Every stage advances together while the result buffer has a free entry.
   assign adv = (cnt_ff != 2'd2);
   assign req_stall = !adv || busy;
   assign accept = req_valid && !req_stall;

   adu_moments u_moments (
      .clock(clock),
      .reset(reset),
      .adv(adv),
      .in_valid(accept),
      .in_action(req_action),
      .in_index(req_index),
      .in_param(req_param_value),
      .in_grad(req_gradient),
      .cfg(cfg_ff),
      .busy(busy),
      .out_valid(mom_valid),
      .out(mom)
   );

   adu_bcdiv u_bcdiv (
      .clock(clock),
      .reset(reset),
      .adv(adv),
      .in_valid(mom_valid),
      .in(mom),
      .out_valid(bias_valid),
      .out(bias)
   );

   adu_sqrt u_sqrt (
      .clock(clock),
      .reset(reset),
      .adv(adv),
      .in_valid(bias_valid),
      .in(bias),
      .out_valid(root_valid),
      .out(root)
   );

   // Denominator and numerator of the step. A zero denominator counts as one LSB.
   // Dropping the low 8 bits of the product first gives the same floor as dividing
   // by den shifted left by 8.
   always_comb begin
      den = {1'b0, root.root} + {9'd0, cfg_ff.eps};
      if (den == 25'd0) begin
         den = 25'd1;
      end
      prod = {32'd0, cfg_ff.lr} * {24'd0, root.mh};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quot_valid_ff <= 1'b0;
      end else if (adv) begin
         quot_valid_ff <= root_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         quot_ff.tag <= root.tag;
         quot_ff.neg <= root.neg;
         quot_ff.num <= prod[55:8];
         quot_ff.den <= den;
      end
   end

   adu_stepdiv u_stepdiv (
      .clock(clock),
      .reset(reset),
      .adv(adv),
      .in_valid(quot_valid_ff),
      .in(quot_ff),
      .out_valid(step_valid),
      .out(step)
   );

   // Apply the step: the parameter moves against the sign of m_hat, then clamps.
   always_comb begin
      pe = {{18{step.tag.param[31]}}, step.tag.param};
      if (step.neg) begin
         res = pe + $signed({2'b00, step.step});
      end else begin
         res = pe - $signed({2'b00, step.step});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else if (adv) begin
         fin_valid_ff <= step_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fin_ff.idx <= step.tag.idx;
         if (res > 50'sh0_0000_7FFF_FFFF) begin
            fin_ff.param <= 32'sh7FFF_FFFF;
            fin_ff.sat <= 1'b1;
         end else if (res < -50'sh0_0000_8000_0000) begin
            fin_ff.param <= 32'sh8000_0000;
            fin_ff.sat <= 1'b1;
         end else begin
            fin_ff.param <= res[31:0];
            fin_ff.sat <= step.tag.sat;
         end
      end
   end

   // Two-entry result buffer. Entry 0 is the head shown on the result channel.
   assign push = fin_valid_ff && adv;
   assign pop = (cnt_ff != 2'd0) && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         if (push && cnt_ff == 2'd1) begin
            ent0_ff <= fin_ff;
         end else begin
            ent0_ff <= ent1_ff;
            if (push) begin
               ent1_ff <= fin_ff;
            end
         end
      end else if (push) begin
         if (cnt_ff == 2'd0) begin
            ent0_ff <= fin_ff;
         end else begin
            ent1_ff <= fin_ff;
         end
      end
   end

   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_out_index = ent0_ff.idx;
   assign rsp_new_param = ent0_ff.param;
   assign rsp_saturated = ent0_ff.sat;

endmodule
